// ----- design/bounded_stack_deque_engine_top_defines.svh -----
// Assertion macros used by the operand stack top level.
`ifndef BOUNDED_STACK_DEQUE_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_STACK_DEQUE_ENGINE_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define BSDE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define BSDE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bsde_pkg.sv -----
// Package with field widths and command and status codes of the operand stack.
`timescale 1ns / 1ps

package bsde_pkg;

    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_W   = 9;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_TOP    = 3'd0,
        CMD_PUSH_BOTTOM = 3'd1,
        CMD_POP         = 3'd2,
        CMD_SWAP        = 3'd3,
        CMD_NOP         = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

// ----- design/bounded_stack_deque_engine_top.sv -----
// Top level of the bounded operand stack with push at either end.
// Results: a command is taken into the input register and executed into the result
//   register once that register is free to accept it.
// Throughput: one command per cycle unless the result stalls; the top two entries live in
//   registers and the third is prefetched through the store's read port every cycle.
// Reset: head, count and all valid flags clear; the entry store is not cleared.
`timescale 1ns / 1ps
`include "bounded_stack_deque_engine_top_defines.svh"

module bounded_stack_deque_engine_top
    import bsde_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] command, [34:3] value, [39:35] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [33:2] top_value, [42:34] depth, [47:43] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AddrW = $clog2(DEPTH);
    localparam int CntW  = $clog2(DEPTH + 1);
    localparam int SumW  = CntW + 1;

    // Ring position helpers
    function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] pos,
                                                  input logic [CntW-1:0]  off);
        logic [SumW-1:0] s;
        s = SumW'(pos) + SumW'(off);
        if (s >= SumW'(DEPTH)) begin
            s = s - SumW'(DEPTH);
        end
        return s[AddrW-1:0];
    endfunction

    function automatic logic [AddrW-1:0] ring_prev(input logic [AddrW-1:0] pos);
        logic [AddrW-1:0] r;
        if (pos == '0) begin
            r = AddrW'(DEPTH - 1);
        end else begin
            r = pos - AddrW'(1);
        end
        return r;
    endfunction

    // Input register
    logic               in_valid_reg;
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [VALUE_W-1:0] in_value_reg;

    // Stack state: top two entries cached, the rest in the store
    logic [AddrW-1:0]   head_reg, head_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic [VALUE_W-1:0] top_reg, top_next;
    logic [VALUE_W-1:0] sec_reg, sec_next;

    // Forwarding of a store write that collides with the prefetch read
    logic               fwd_hit_reg;
    logic [VALUE_W-1:0] fwd_data_reg;

    // Result register
    logic               m_valid_reg;
    status_t            m_status_reg, status_next;
    logic [VALUE_W-1:0] m_top_reg;
    logic [DEPTH_W-1:0] m_depth_reg;

    // Store ports
    logic               wr_en;
    logic               op_wr;
    logic [AddrW-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AddrW-1:0]   rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic [VALUE_W-1:0] third_val;

    logic               exec_fire;
    logic [AddrW-1:0]   head_after;
    logic [VALUE_W-1:0] top_out;

    assign exec_fire     = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec_fire;
    assign third_val     = fwd_hit_reg ? fwd_data_reg : rd_data;

    // Decode one command against the cached top two entries
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        sec_next    = sec_reg;
        status_next = ST_OK;
        op_wr       = 1'b0;
        wr_addr     = ring_add(head_reg, CntW'(1));
        wr_data     = sec_reg;
        case (cmd_t'(in_cmd_reg))
            CMD_PUSH_TOP: begin
                if (count_reg == CntW'(DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    // spill the old second entry, shift the top down
                    op_wr      = 1'b1;
                    sec_next   = top_reg;
                    top_next   = in_value_reg;
                    count_next = count_reg + CntW'(1);
                    if (count_reg != '0) begin
                        head_next = ring_prev(head_reg);
                    end
                end
            end
            CMD_PUSH_BOTTOM: begin
                if (count_reg == CntW'(DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    op_wr      = 1'b1;
                    wr_addr    = ring_add(head_reg, count_reg);
                    wr_data    = in_value_reg;
                    count_next = count_reg + CntW'(1);
                    if (count_reg == '0) begin
                        top_next = in_value_reg;
                    end else if (count_reg == CntW'(1)) begin
                        sec_next = in_value_reg;
                    end
                end
            end
            CMD_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    top_next   = sec_reg;
                    sec_next   = third_val;
                    count_next = count_reg - CntW'(1);
                    if (count_reg != CntW'(1)) begin
                        head_next = ring_add(head_reg, CntW'(1));
                    end
                end
            end
            CMD_SWAP: begin
                if (count_reg < CntW'(2)) begin
                    status_next = ST_SHORT;
                end else begin
                    top_next = sec_reg;
                    sec_next = top_reg;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    assign wr_en      = exec_fire && op_wr;
    assign head_after = exec_fire ? head_next : head_reg;
    // Prefetch the third entry for the head that holds next cycle
    assign rd_addr    = ring_add(head_after, CntW'(2));
    assign top_out    = (count_next != '0) ? top_next : '0;

    // Advance input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg   <= s_axis_tdata[CMD_W-1:0];
            in_value_reg <= s_axis_tdata[CMD_W +: VALUE_W];
        end
    end

    // Update stack state and forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            count_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (exec_fire) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
        if (exec_fire) begin
            top_reg <= top_next;
            sec_reg <= sec_next;
        end
        fwd_data_reg <= wr_data;
    end

    // Hold result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (exec_fire) begin
            m_status_reg <= status_next;
            m_top_reg    <= top_out;
            m_depth_reg  <= DEPTH_W'(count_next);
        end
    end

    bsde_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - STATUS_W - VALUE_W - DEPTH_W){1'b0}},
                            m_depth_reg, m_top_reg, m_status_reg};

    `BSDE_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CntW'(DEPTH),
        "entry count above capacity")
    `BSDE_ASSERT_NEXT(a_fail_keeps_count, aclk, aresetn,
        exec_fire && status_next != ST_OK, count_reg == $past(count_reg),
        "failed command changed the entry count")
    `BSDE_ASSERT_NEXT(a_push_grows, aclk, aresetn,
        exec_fire && op_wr, count_reg == $past(count_reg) + CntW'(1),
        "successful push did not add one entry")
    `BSDE_ASSERT_NOW(a_depth_tracks, aclk, aresetn, m_valid_reg,
        m_depth_reg == DEPTH_W'(count_reg), "reported depth differs from entry count")

endmodule

// ----- design/bsde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port; read returns the old contents on an address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
